// ===== hw/rtl/bpdc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpdc_pkg
// Types and constants shared by the PI duty controller modules.
// ----------------------------------------------------------------------------
package bpdc_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SETPOINT     = 3'd0,
    REG_MV_PER_COUNT = 3'd1,
    REG_KP           = 3'd2,
    REG_KI           = 3'd3,
    REG_MAX_DUTY     = 3'd4
  } cfg_reg_e;

  localparam int SETP_W = 16;
  localparam int MVPC_W = 14;
  localparam int GAIN_W = 16;
  localparam int PWM_W  = 8;
  localparam int LOAD_W = 16;

  typedef struct packed {
    logic [SETP_W-1:0] setpoint_mv;
    logic [MVPC_W-1:0] mv_per_count_q8;
    logic [GAIN_W-1:0] kp_q16;
    logic [GAIN_W-1:0] ki_q16;
    logic [PWM_W-1:0]  max_duty;
  } cfg_t;

  localparam logic [SETP_W-1:0] SETPOINT_RST = 16'd5000;
  localparam logic [MVPC_W-1:0] MVPC_RST     = 14'd4693;
  localparam logic [GAIN_W-1:0] KP_RST       = 16'd1678;
  localparam logic [GAIN_W-1:0] KI_RST       = 16'd0;
  localparam logic [PWM_W-1:0]  MAX_DUTY_RST = 8'd250;

  // arithmetic formats
  localparam int SCALE_SHIFT = 8;   // Q6.8 gain
  localparam int FRAC_W      = 16;  // Q16 duty and gains
  localparam int ERR_W       = LOAD_W + 1;
  localparam int DUTY_W      = 40;
  localparam int ESUM_W      = 32;

  localparam logic [DUTY_W-1:0] DUTY_RST = 40'd3276800;
  localparam logic [DUTY_W-1:0] DUTY_MAX = {1'b0, {(DUTY_W-1){1'b1}}};
  localparam logic [DUTY_W-1:0] DUTY_MIN = {1'b1, {(DUTY_W-1){1'b0}}};
  localparam logic [ESUM_W-1:0] ESUM_MAX = {1'b0, {(ESUM_W-1){1'b1}}};
  localparam logic [ESUM_W-1:0] ESUM_MIN = {1'b1, {(ESUM_W-1){1'b0}}};

  // digit-serial multiply-accumulate unit
  localparam int ACC_W      = 50;  // holds duty - kp*err - ki*esum exactly
  localparam int MUL_A_W    = 32;  // signed multiplicand
  localparam int MUL_B_W    = 16;  // unsigned multiplier, consumed by digits
  localparam int DIG_W      = 4;
  localparam int MAC_DIGITS = MUL_B_W / DIG_W;
  localparam int MAC_CNT_W  = $clog2(MAC_DIGITS + 1);

  typedef struct packed {
    logic               start;
    logic               use_init;  // start from init instead of current sum
    logic               sub;
    logic [ACC_W-1:0]   init;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mac_req_t;

  typedef struct packed {
    logic             busy;
    logic [ACC_W-1:0] acc;
  } mac_rsp_t;

endpackage

// ===== hw/rtl/bpdc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpdc channel interfaces
// Valid/ready channels for ADC samples and duty results.
// ----------------------------------------------------------------------------
interface bpdc_in_if #(
  parameter int ADC_BITS = 10
);
  logic                valid;
  logic                ready;
  logic [ADC_BITS-1:0] adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink   (input valid, input adc_sample, output ready);
endinterface

interface bpdc_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  pwm_compare;
  logic        clamped_low;
  logic        clamped_high;
  logic [15:0] load_mv;

  modport source (output valid, output pwm_compare, output clamped_low,
                  output clamped_high, output load_mv, input ready);
  modport sink   (input valid, input pwm_compare, input clamped_low,
                  input clamped_high, input load_mv, output ready);
endinterface

// ===== hw/rtl/bpdc_mac.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpdc_mac
// Digit-serial multiply-accumulate: acc +/- a*b, four multiplier bits a cycle.
// ----------------------------------------------------------------------------
module bpdc_mac (
  input  logic               clk,
  input  logic               rst_n,
  input  bpdc_pkg::mac_req_t req,
  output bpdc_pkg::mac_rsp_t rsp
);
  import bpdc_pkg::*;

  logic [ACC_W-1:0]     acc_r;
  logic [ACC_W-1:0]     a_r;
  logic [MUL_B_W-1:0]   b_r;
  logic                 sub_r;
  logic [MAC_CNT_W-1:0] cnt_r;
  logic [ACC_W-1:0]     pp;

  // a_r carries the digit weight: it is shifted left one digit per cycle
  assign pp = ACC_W'($signed(a_r) * $signed({1'b0, b_r[DIG_W-1:0]}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (req.start) begin
      cnt_r <= MAC_CNT_W'(MAC_DIGITS);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      if (req.use_init) begin
        acc_r <= req.init;
      end
      a_r   <= {{(ACC_W-MUL_A_W){req.a[MUL_A_W-1]}}, req.a};
      b_r   <= req.b;
      sub_r <= req.sub;
    end else if (cnt_r != '0) begin
      acc_r <= sub_r ? acc_r - pp : acc_r + pp;
      a_r   <= a_r << DIG_W;
      b_r   <= b_r >> DIG_W;
    end
  end

  assign rsp.busy = (cnt_r != '0);
  assign rsp.acc  = acc_r;

endmodule

// ===== hw/rtl/bpdc_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpdc_seq
// Sequencer: scale, PI correction on the shared MAC, state update, output.
// ----------------------------------------------------------------------------
module bpdc_seq #(
  parameter int ADC_BITS = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  bpdc_pkg::cfg_t     cfg,
  bpdc_in_if.sink            in_ch,
  bpdc_out_if.source         out_ch,
  output bpdc_pkg::mac_req_t mac_req,
  input  bpdc_pkg::mac_rsp_t mac_rsp
);
  import bpdc_pkg::*;

  localparam int TOP_W = ACC_W - DUTY_W + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCALE,
    S_KP,
    S_KI,
    S_PUSH
  } state_t;

  state_t              state_r;
  logic [DUTY_W-1:0]   duty_r;
  logic [ESUM_W-1:0]   esum_r;
  logic [ERR_W-1:0]    err_r;
  logic [LOAD_W-1:0]   load_r;
  logic [PWM_W-1:0]    pend_pwm_r;
  logic                pend_lo_r;
  logic                pend_hi_r;
  logic                out_valid_r;
  logic [PWM_W-1:0]    out_pwm_r;
  logic                out_lo_r;
  logic                out_hi_r;
  logic [LOAD_W-1:0]   out_load_r;

  logic [LOAD_W-1:0]   load_c;
  logic [ERR_W-1:0]    err_c;
  logic [TOP_W-1:0]    acc_top;
  logic [DUTY_W-1:0]   duty_c;
  logic [ESUM_W:0]     esum_sum;
  logic [ESUM_W-1:0]   esum_c;
  logic [PWM_W-1:0]    pwm_c;
  logic                lo_c;
  logic                hi_c;
  logic                slot_free;

  // load voltage from the scaling product, saturated to 16 bits
  always_comb begin
    if (|mac_rsp.acc[ACC_W-1:SCALE_SHIFT+LOAD_W]) begin
      load_c = '1;
    end else begin
      load_c = mac_rsp.acc[SCALE_SHIFT+LOAD_W-1:SCALE_SHIFT];
    end
    err_c = {1'b0, load_c} - {1'b0, cfg.setpoint_mv};
  end

  // accumulator saturation, error sum update and output clamp
  always_comb begin
    acc_top = mac_rsp.acc[ACC_W-1:DUTY_W-1];
    if (&acc_top || ~|acc_top) begin
      duty_c = mac_rsp.acc[DUTY_W-1:0];
    end else if (mac_rsp.acc[ACC_W-1]) begin
      duty_c = DUTY_MIN;
    end else begin
      duty_c = DUTY_MAX;
    end

    esum_sum = {esum_r[ESUM_W-1], esum_r}
             + {{(ESUM_W+1-ERR_W){err_r[ERR_W-1]}}, err_r};
    if (esum_sum[ESUM_W] == esum_sum[ESUM_W-1]) begin
      esum_c = esum_sum[ESUM_W-1:0];
    end else if (esum_sum[ESUM_W]) begin
      esum_c = ESUM_MIN;
    end else begin
      esum_c = ESUM_MAX;
    end

    lo_c  = 1'b0;
    hi_c  = 1'b0;
    if (duty_c[DUTY_W-1]) begin
      pwm_c = '0;
      lo_c  = 1'b1;
    end else if (duty_c > DUTY_W'({cfg.max_duty, {FRAC_W{1'b0}}})) begin
      pwm_c = cfg.max_duty;
      hi_c  = 1'b1;
    end else begin
      pwm_c = duty_c[FRAC_W+PWM_W-1:FRAC_W];
    end
  end

  // MAC issue: scale, then duty - kp*err, then - ki*esum (sum before update)
  always_comb begin
    mac_req = '0;
    case (state_r)
      S_IDLE: begin
        mac_req.start    = in_ch.valid;
        mac_req.use_init = 1'b1;
        mac_req.a        = {{(MUL_A_W-ADC_BITS){1'b0}}, in_ch.adc_sample};
        mac_req.b        = {{(MUL_B_W-MVPC_W){1'b0}}, cfg.mv_per_count_q8};
      end
      S_SCALE: begin
        mac_req.start    = !mac_rsp.busy;
        mac_req.use_init = 1'b1;
        mac_req.sub      = 1'b1;
        mac_req.init     = {{(ACC_W-DUTY_W){duty_r[DUTY_W-1]}}, duty_r};
        mac_req.a        = {{(MUL_A_W-ERR_W){err_c[ERR_W-1]}}, err_c};
        mac_req.b        = cfg.kp_q16;
      end
      S_KP: begin
        mac_req.start    = !mac_rsp.busy;
        mac_req.sub      = 1'b1;
        mac_req.a        = esum_r;
        mac_req.b        = cfg.ki_q16;
      end
      default: begin
        mac_req = '0;
      end
    endcase
  end

  assign slot_free = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      duty_r      <= DUTY_RST;
      esum_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            state_r <= S_SCALE;
          end
        end
        S_SCALE: begin
          if (!mac_rsp.busy) begin
            load_r  <= load_c;
            err_r   <= err_c;
            state_r <= S_KP;
          end
        end
        S_KP: begin
          if (!mac_rsp.busy) begin
            state_r <= S_KI;
          end
        end
        S_KI: begin
          if (!mac_rsp.busy) begin
            duty_r     <= duty_c;
            esum_r     <= esum_c;
            pend_pwm_r <= pwm_c;
            pend_lo_r  <= lo_c;
            pend_hi_r  <= hi_c;
            state_r    <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (slot_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase

      if (state_r == S_PUSH && slot_free) begin
        out_valid_r <= 1'b1;
        out_pwm_r   <= pend_pwm_r;
        out_lo_r    <= pend_lo_r;
        out_hi_r    <= pend_hi_r;
        out_load_r  <= load_r;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.pwm_compare  = out_pwm_r;
  assign out_ch.clamped_low  = out_lo_r;
  assign out_ch.clamped_high = out_hi_r;
  assign out_ch.load_mv      = out_load_r;

endmodule

// ===== hw/rtl/boost_pi_duty_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// boost_pi_duty_controller
// PI regulator turning load voltage samples into a PWM compare value.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one raw ADC sample of the load voltage per transaction.
//   out_ch : one result per sample: clamped compare value, clamp flags and
//            the scaled load voltage in mV.
//   cfg_*  : write-only registers (setpoint, mV per count, kp, ki, max duty),
//            written while the block is idle; unknown indexes are dropped.
// Timing: the three multiplications (scaling, kp*error, ki*error sum) run on
//   one shared multiply-accumulate unit that consumes 4 multiplier bits per
//   cycle, one multiplication after the other. A new sample is taken only
//   after the result of the last one has gone to the output register.
// Reset: registers return to their defaults, the duty accumulator to 50.0
//   counts, the error sum to zero, and the output register is emptied.
// Stall: a finished result waits in the output register; the next sample is
//   still taken and worked on, and its result is held until the slot frees.
// ----------------------------------------------------------------------------
module boost_pi_duty_controller #(
  parameter int ADC_BITS = 10
) (
  input  logic                            clk,
  input  logic                            rst_n,
  bpdc_in_if.sink                         in_ch,
  bpdc_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [bpdc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bpdc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import bpdc_pkg::*;

  cfg_t     cfg_r;
  mac_req_t mac_req;
  mac_rsp_t mac_rsp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.setpoint_mv     <= SETPOINT_RST;
      cfg_r.mv_per_count_q8 <= MVPC_RST;
      cfg_r.kp_q16          <= KP_RST;
      cfg_r.ki_q16          <= KI_RST;
      cfg_r.max_duty        <= MAX_DUTY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SETPOINT:     cfg_r.setpoint_mv     <= cfg_wdata[SETP_W-1:0];
        REG_MV_PER_COUNT: cfg_r.mv_per_count_q8 <= cfg_wdata[MVPC_W-1:0];
        REG_KP:           cfg_r.kp_q16          <= cfg_wdata[GAIN_W-1:0];
        REG_KI:           cfg_r.ki_q16          <= cfg_wdata[GAIN_W-1:0];
        REG_MAX_DUTY:     cfg_r.max_duty        <= cfg_wdata[PWM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  bpdc_seq #(
    .ADC_BITS (ADC_BITS)
  ) u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .mac_req (mac_req),
    .mac_rsp (mac_rsp)
  );

  bpdc_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mac_req),
    .rsp   (mac_rsp)
  );

endmodule

// ===== hw/rtl/bpdc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpdc_checker
// Port-level assertions for the PI duty controller, bound to the top level.
// ----------------------------------------------------------------------------
module bpdc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  pwm_compare,
  input logic        clamped_low,
  input logic        clamped_high,
  input logic [15:0] load_mv
);

  // one sample at a time: taking one closes the input until it is done
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again right after a transaction");

  // a result never shows up in the cycle after its sample was taken
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result appeared too early");

  a_reset_empties_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_clamp_low_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && clamped_low |-> pwm_compare == 8'd0 && !clamped_high)
    else $error("low clamp with nonzero compare or both flags");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(pwm_compare)
      && $stable(load_mv) && $stable(clamped_low) && $stable(clamped_high))
    else $error("stalled result changed");

endmodule

bind boost_pi_duty_controller bpdc_checker u_bpdc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .pwm_compare  (out_ch.pwm_compare),
  .clamped_low  (out_ch.clamped_low),
  .clamped_high (out_ch.clamped_high),
  .load_mv      (out_ch.load_mv)
);

// ===== tb/sv/bpdc_duty_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpdc_duty_checker
// Passive checker for the PI duty controller: tracks register writes, predicts
// the duty result of every accepted sample and compares it field by field
// with the results taken from the output channel, oldest first.
// ----------------------------------------------------------------------------
module bpdc_duty_checker #(
  parameter int ADC_BITS = 10
) (
  input  logic                            clk,
  input  logic                            rst_n,
  bpdc_in_if                              in_ch,
  bpdc_out_if                             out_ch,
  input  logic                            cfg_we,
  input  logic [bpdc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bpdc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                              fail_count,
  output int                              pending
);
  import bpdc_pkg::*;

  typedef struct packed {
    logic [PWM_W-1:0]  pwm_compare;
    logic              clamped_low;
    logic              clamped_high;
    logic [LOAD_W-1:0] load_mv;
  } duty_result_t;

  localparam longint DUTY_HI = (longint'(1) <<< (DUTY_W - 1)) - 1;
  localparam longint DUTY_LO = -DUTY_HI - 1;
  localparam longint ESUM_HI = (longint'(1) <<< (ESUM_W - 1)) - 1;
  localparam longint ESUM_LO = -ESUM_HI - 1;
  localparam longint LOAD_HI = (longint'(1) <<< LOAD_W) - 1;

  cfg_t                     regs;
  logic signed [DUTY_W-1:0] duty_acc;
  logic signed [ESUM_W-1:0] err_sum;
  duty_result_t             expected_q[$];
  int                       mismatches;

  // Advances the controller state by one sample and returns its result.
  function automatic duty_result_t next_duty(logic [ADC_BITS-1:0] sample);
    longint       scaled;
    longint       load;
    longint       err;
    longint       corr;
    longint       acc;
    longint       sum;
    duty_result_t r;
    scaled = (longint'(sample) * longint'(regs.mv_per_count_q8)) >>> SCALE_SHIFT;
    load   = (scaled > LOAD_HI) ? LOAD_HI : scaled;
    err    = load - longint'(regs.setpoint_mv);
    // integral term uses the error sum from before this sample
    corr   = longint'(regs.kp_q16) * err + longint'(regs.ki_q16) * longint'(err_sum);
    acc    = longint'(duty_acc) - corr;
    if (acc > DUTY_HI) acc = DUTY_HI;
    if (acc < DUTY_LO) acc = DUTY_LO;
    duty_acc = acc[DUTY_W-1:0];
    sum = longint'(err_sum) + err;
    if (sum > ESUM_HI) sum = ESUM_HI;
    if (sum < ESUM_LO) sum = ESUM_LO;
    err_sum = sum[ESUM_W-1:0];

    r = '0;
    r.load_mv = load[LOAD_W-1:0];
    if (acc < 0) begin
      r.clamped_low = 1'b1;
    end else if (acc > (longint'(regs.max_duty) <<< FRAC_W)) begin
      r.pwm_compare  = regs.max_duty;
      r.clamped_high = 1'b1;
    end else begin
      r.pwm_compare = PWM_W'(acc >>> FRAC_W);
    end
    return r;
  endfunction

  always @(posedge clk) begin
    duty_result_t want;
    duty_result_t got;
    if (!rst_n) begin
      regs.setpoint_mv     = SETPOINT_RST;
      regs.mv_per_count_q8 = MVPC_RST;
      regs.kp_q16          = KP_RST;
      regs.ki_q16          = KI_RST;
      regs.max_duty        = MAX_DUTY_RST;
      duty_acc             = DUTY_RST;
      err_sum              = '0;
      mismatches           = 0;
      expected_q.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.pwm_compare, out_ch.clamped_low, out_ch.clamped_high, out_ch.load_mv};
        if (expected_q.size() == 0) begin
          $error("duty result transaction with no sample pending: pwm_compare %0d",
                 got.pwm_compare);
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          if (got.pwm_compare !== want.pwm_compare) begin
            $error("pwm_compare: expected %0d, actual %0d", want.pwm_compare, got.pwm_compare);
            mismatches++;
          end
          if (got.clamped_low !== want.clamped_low) begin
            $error("clamped_low: expected %0b, actual %0b", want.clamped_low, got.clamped_low);
            mismatches++;
          end
          if (got.clamped_high !== want.clamped_high) begin
            $error("clamped_high: expected %0b, actual %0b",
                   want.clamped_high, got.clamped_high);
            mismatches++;
          end
          if (got.load_mv !== want.load_mv) begin
            $error("load_mv: expected %0d, actual %0d", want.load_mv, got.load_mv);
            mismatches++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        expected_q.push_back(next_duty(in_ch.adc_sample));
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_SETPOINT:     regs.setpoint_mv     = cfg_wdata[SETP_W-1:0];
          REG_MV_PER_COUNT: regs.mv_per_count_q8 = cfg_wdata[MVPC_W-1:0];
          REG_KP:           regs.kp_q16          = cfg_wdata[GAIN_W-1:0];
          REG_KI:           regs.ki_q16          = cfg_wdata[GAIN_W-1:0];
          REG_MAX_DUTY:     regs.max_duty        = cfg_wdata[PWM_W-1:0];
          default: ;
        endcase
      end
    end
    fail_count <= mismatches;
    pending    <= expected_q.size();
  end

endmodule

// ===== tb/sv/boost_pi_duty_controller_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// boost_pi_duty_controller_tb
// Drives ADC samples and register writes into the duty controller: a short
// directed part on the clamp boundaries and register extremes, then random
// phases whose samples follow a crude boost plant fed by the returned duty,
// under several sender/receiver idling patterns. The checker does the rest.
// ----------------------------------------------------------------------------
module boost_pi_duty_controller_tb;
  import bpdc_pkg::*;

  localparam int ADC_BITS     = 10;
  localparam int ADC_MAX      = (1 << ADC_BITS) - 1;
  localparam int RUN_LIMIT    = 600000;
  localparam int DRAIN_CYCLES = 40;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    fail_count;
  int                    pending;
  int                    cycle_cnt;
  int                    in_idle_pct   = 0;
  int                    out_stall_pct = 0;
  int                    tgt_adc       = 0;
  int                    cur_max       = MAX_DUTY_RST;
  logic [PWM_W-1:0]      last_pwm      = '0;

  bpdc_in_if #(.ADC_BITS(ADC_BITS)) in_ch ();
  bpdc_out_if                       out_ch ();

  boost_pi_duty_controller #(.ADC_BITS(ADC_BITS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  bpdc_duty_checker #(.ADC_BITS(ADC_BITS)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: random back-pressure, remembers the last duty for the plant
  always @(posedge clk) begin
    if (out_ch.valid && out_ch.ready) begin
      last_pwm <= out_ch.pwm_compare;
    end
    out_ch.ready <= ($urandom_range(99) >= out_stall_pct);
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < RUN_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("** boost_pi_duty_controller: FAILED **");
    $finish;
  end

  // caller lowers cfg_we after the last write of a group
  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic apply_cfg(input cfg_t c);
    logic [CFG_DATA_W-1:0] pad;
    logic [CFG_IDX_W-1:0]  bad_idx;
    pad     = CFG_DATA_W'($urandom);
    bad_idx = CFG_IDX_W'($urandom_range((1 << CFG_IDX_W) - 1, int'(REG_MAX_DUTY) + 1));
    set_reg(bad_idx, CFG_DATA_W'($urandom));
    set_reg(REG_SETPOINT, c.setpoint_mv);
    set_reg(REG_MV_PER_COUNT, {pad[CFG_DATA_W-1:MVPC_W], c.mv_per_count_q8});
    set_reg(REG_KP, c.kp_q16);
    set_reg(REG_KI, c.ki_q16);
    set_reg(REG_MAX_DUTY, {pad[CFG_DATA_W-1:PWM_W], c.max_duty});
    cfg_we <= 1'b0;
    // sample count that lands on the setpoint
    tgt_adc = (c.mv_per_count_q8 == 0) ? 0 :
              (int'(c.setpoint_mv) << SCALE_SHIFT) / int'(c.mv_per_count_q8);
    if (tgt_adc > ADC_MAX) tgt_adc = ADC_MAX;
    cur_max = int'(c.max_duty);
  endtask

  task automatic send_sample(input logic [ADC_BITS-1:0] s);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid      <= 1'b0;
      in_ch.adc_sample <= ADC_BITS'($urandom);
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.adc_sample <= s;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // hold the sender until every sample has its result back
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic cfg_t rand_cfg();
    cfg_t c;
    c.setpoint_mv     = SETP_W'($urandom_range(18000, 500));
    c.mv_per_count_q8 = MVPC_W'($urandom_range(16383, 1000));
    c.kp_q16          = GAIN_W'($urandom_range(5000));
    c.ki_q16          = GAIN_W'($urandom_range(40));
    c.max_duty        = PWM_W'($urandom_range(255, 20));
    return c;
  endfunction

  // load voltage rises with duty; a fifth of the samples are plain noise
  function automatic logic [ADC_BITS-1:0] plant_sample();
    int s;
    if ($urandom_range(99) < 20) return ADC_BITS'($urandom);
    s = tgt_adc + (int'(last_pwm) - cur_max / 2) / 2 + int'($urandom_range(16)) - 8;
    if (s < 0) s = 0;
    if (s > ADC_MAX) s = ADC_MAX;
    return ADC_BITS'(s);
  endfunction

  task automatic run_phase(input cfg_t c, input int n, input int in_pct, input int out_pct);
    wait_idle();
    apply_cfg(c);
    in_idle_pct = in_pct;
    out_stall_pct <= out_pct;
    repeat (n) send_sample(plant_sample());
  endtask

  initial begin
    cfg_t ext;
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= REG_SETPOINT;
    cfg_wdata        <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.adc_sample <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // accumulator sits exactly on 50.0: equal to max_duty is not a clamp
    set_reg(REG_KP, '0);
    set_reg(REG_MAX_DUTY, CFG_DATA_W'(50));
    cfg_we <= 1'b0;
    send_sample('1);
    send_sample('0);
    wait_idle();
    set_reg(REG_MAX_DUTY, CFG_DATA_W'(49));
    cfg_we <= 1'b0;
    send_sample(ADC_BITS'(512));

    // drive into the high clamp, then below zero, then near the setpoint
    wait_idle();
    set_reg(REG_KP, KP_RST);
    set_reg(REG_MAX_DUTY, '1);
    cfg_we <= 1'b0;
    repeat (3) send_sample('0);
    repeat (4) send_sample('1);
    send_sample(ADC_BITS'(273));
    send_sample(ADC_BITS'(272));
    send_sample(ADC_BITS'(274));

    // register extremes
    wait_idle();
    set_reg(REG_MV_PER_COUNT, '0);
    cfg_we <= 1'b0;
    send_sample('1);
    wait_idle();
    set_reg(REG_MV_PER_COUNT, '1);
    cfg_we <= 1'b0;
    send_sample('1);
    send_sample(ADC_BITS'(1));
    wait_idle();
    set_reg(REG_SETPOINT, '0);
    cfg_we <= 1'b0;
    send_sample('0);
    wait_idle();
    set_reg(REG_SETPOINT, '1);
    cfg_we <= 1'b0;
    send_sample('1);
    wait_idle();
    set_reg(REG_MAX_DUTY, '0);
    cfg_we <= 1'b0;
    send_sample(ADC_BITS'(512));

    run_phase(rand_cfg(), 450, 0, 0);
    run_phase(rand_cfg(), 350, 85, 0);
    run_phase(rand_cfg(), 350, 0, 85);
    run_phase(rand_cfg(), 350, 16, 16);
    run_phase(rand_cfg(), 200, 0, 0);

    // full gains: accumulator runs into its positive, then negative limit
    ext = '{setpoint_mv: '1, mv_per_count_q8: '1, kp_q16: '1, ki_q16: '1, max_duty: '1};
    run_phase(ext, 40, 16, 16);
    ext.setpoint_mv = '0;
    run_phase(ext, 100, 16, 16);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("** boost_pi_duty_controller: PASSED **");
    end else begin
      $display("** boost_pi_duty_controller: FAILED **");
    end
    $finish;
  end

endmodule
